/* design/bfs_pkg.sv */
package bfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERTEX_W     = 6;
  localparam int QIDX_W       = 6;
  localparam int QCNT_W       = 7;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int VCOUNT_W     = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_EDGE = 2'd0,
    REQ_SEARCH   = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VISITED       = 2'd0,
    ST_EDGE_REJECTED = 2'd1,
    ST_BAD_START     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REJECT,
    S_ADD_A,
    S_ADD_B,
    S_SEARCH_START,
    S_BAD_START,
    S_POP,
    S_HEAD,
    S_LINK,
    S_WALK,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    HRD_INPUT,
    HRD_ITEM_B,
    HRD_QUEUE
  } head_src_t;

  typedef enum logic [1:0] {
    OUT_MID,
    OUT_LAST,
    OUT_REJECT,
    OUT_BAD_START
  } out_kind_t;

  typedef struct packed {
    logic      item_load;
    head_src_t head_rd_src;
    logic      list_clear;
    logic      link_a_write;
    logic      link_b_write;
    logic      search_init;
    logic      pop;
    logic      pend_capture;
    logic      entry_rd_next;
    logic      walk_visit;
    logic      out_load;
    out_kind_t out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic add_ok;
    logic start_ok;
    logic queue_empty;
    logic pend_valid;
    logic head_link_zero;
    logic next_link_zero;
  } dp_status_t;

endpackage

/* design/bfs_if.sv */
interface bfs_req_if import bfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [VERTEX_W-1:0] first_vertex;
  logic [VERTEX_W-1:0] second_vertex;

  modport source (output valid, req_type, first_vertex, second_vertex, input ready);
  modport sink (input valid, req_type, first_vertex, second_vertex, output ready);
endinterface

interface bfs_res_if import bfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] visited_vertex;
  logic [STATUS_W-1:0] result_status;
  logic                last_result;

  modport source (output valid, visited_vertex, result_status, last_result, input ready);
  modport sink (input valid, visited_vertex, result_status, last_result, output ready);
endinterface

/* design/graph_breadth_first_search.sv */
// Breadth-first search over an undirected graph held as neighbor lists.
// req channel (valid/ready): add edge, run search, or clear all lists.
// res channel (valid/ready): results out of a one-entry output register.
// APB port: register 0 at address 0 is vertex_count (reset 64).
// An add edge is accepted in S_IDLE and goes on through S_ADD_A, S_ADD_B:
// a head read per end plus two list insertions on head and entry memory.
// A rejected edge or a bad start vertex gives one result, last_result set.
// A search takes, for each vertex reached, a queue read, a head read and a
// link check, then one entry-memory read per neighbor entry walked. Each
// vertex is emitted when the next one leaves the queue or the walk ends,
// so the final one carries the flag. A clear is done at acceptance.
// Requests are taken only when the controller is idle; a finished result
// may still wait in the output reg. Reset (synchronous, active high)
// empties all lists and the queue, clears visited marks and the output
// valid flag. If the receiver stalls, the result register holds and the
// search waits at its next emit.
module graph_breadth_first_search import bfs_pkg::*; #(
  parameter int MAX_EDGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  bfs_req_if.sink     req,
  bfs_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [VCOUNT_W-1:0] vertex_count;
  ctrl_cmd_t           cmd;
  dp_status_t          status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - VCOUNT_W){1'b0}}, vertex_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      vertex_count <= pwdata[VCOUNT_W-1:0];
    end
  end

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bfs_dpath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .first_vertex  (req.first_vertex),
    .second_vertex (req.second_vertex),
    .vertex_count  (vertex_count),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .out_vertex    (res.visited_vertex),
    .out_status    (res.result_status),
    .out_last      (res.last_result)
  );

endmodule

/* design/bfs_ctrl.sv */
module bfs_ctrl import bfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [REQ_W-1:0] req_type,
  output logic             req_ready,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready       = 1'b1;
        cmd.head_rd_src = HRD_INPUT;
        if (req_valid) begin
          cmd.item_load = 1'b1;
          unique case (req_type)
            REQ_ADD_EDGE: state_next = status.add_ok ? S_ADD_A : S_REJECT;
            REQ_SEARCH:   state_next = S_SEARCH_START;
            REQ_CLEAR:    cmd.list_clear = 1'b1;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_REJECT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_REJECT;
          state_next   = S_IDLE;
        end
      end
      S_ADD_A: begin
        // head of a is in; fetch head of b for the second insertion
        cmd.link_a_write = 1'b1;
        cmd.head_rd_src  = HRD_ITEM_B;
        state_next       = S_ADD_B;
      end
      S_ADD_B: begin
        cmd.link_b_write = 1'b1;
        state_next       = S_IDLE;
      end
      S_SEARCH_START: begin
        cmd.search_init = 1'b1;
        state_next      = status.start_ok ? S_POP : S_BAD_START;
      end
      S_BAD_START: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_BAD_START;
          state_next   = S_IDLE;
        end
      end
      S_POP: begin
        if (status.queue_empty) begin
          state_next = S_FINAL;
        end else if (!status.pend_valid || status.out_free) begin
          // previous vertex is known not to be last once another is queued
          cmd.pop      = 1'b1;
          cmd.out_load = status.pend_valid;
          cmd.out_kind = OUT_MID;
          state_next   = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.pend_capture = 1'b1;
        cmd.head_rd_src  = HRD_QUEUE;
        state_next       = S_LINK;
      end
      S_LINK: begin
        cmd.entry_rd_next = 1'b0;
        state_next        = status.head_link_zero ? S_POP : S_WALK;
      end
      S_WALK: begin
        cmd.walk_visit    = 1'b1;
        cmd.entry_rd_next = 1'b1;
        state_next        = status.next_link_zero ? S_POP : S_WALK;
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_LAST;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/bfs_dpath.sv */
module bfs_dpath import bfs_pkg::*; #(
  parameter int MAX_EDGES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  logic [VERTEX_W-1:0] first_vertex,
  input  logic [VERTEX_W-1:0] second_vertex,
  input  logic [VCOUNT_W-1:0] vertex_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  localparam int ENTRY_COUNT = 2 * MAX_EDGES;
  localparam int LINK_W      = $clog2(ENTRY_COUNT + 1);
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int ENTRY_W     = VERTEX_W + LINK_W;

  logic [VERTEX_W-1:0] item_a, item_b;
  logic [LINK_W-1:0]   used;

  // neighbor lists: head per vertex, link 0 = empty, else entry + 1
  logic [LINK_W-1:0]       head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_valid;
  logic [LINK_W-1:0]       head_rdata;
  logic                    head_vld_q;
  logic [ENTRY_W-1:0]      entry_mem [ENTRY_COUNT];
  logic [ENTRY_W-1:0]      entry_rdata;

  logic [VERTEX_W-1:0]     queue_mem [MAX_VERTICES];
  logic [VERTEX_W-1:0]     q_rdata;
  logic [QCNT_W-1:0]       rd_idx, wr_idx;
  logic [MAX_VERTICES-1:0] visited;
  logic [VERTEX_W-1:0]     pend_vertex;
  logic                    pend_valid;

  logic [VERTEX_W-1:0] head_rd_addr, head_wr_addr;
  logic                head_wr_en;
  logic [LINK_W-1:0]   head_link, link_b, used_inc, entry_next, entry_rd_link;
  logic [ENTRY_W-1:0]  entry_wr_data;
  logic [IDX_W-1:0]    entry_rd_addr;
  logic [VERTEX_W-1:0] entry_nb;
  logic                start_ok, nb_new, q_wr_en;
  logic [QIDX_W-1:0]   q_wr_addr;
  logic [VERTEX_W-1:0] q_wr_data;

  always_comb begin
    unique case (cmd.head_rd_src)
      HRD_ITEM_B: head_rd_addr = item_b;
      HRD_QUEUE:  head_rd_addr = q_rdata;
      default:    head_rd_addr = first_vertex;
    endcase
  end

  assign head_link  = head_vld_q ? head_rdata : '0;
  // self loop: head of b was just written by the first insertion
  assign link_b     = (item_a == item_b) ? used : head_link;
  assign used_inc   = used + LINK_W'(1);
  assign head_wr_en = cmd.link_a_write || cmd.link_b_write;
  assign head_wr_addr  = cmd.link_b_write ? item_b : item_a;
  assign entry_wr_data = cmd.link_b_write ? {item_a, link_b} : {item_b, head_link};

  assign entry_nb      = entry_rdata[ENTRY_W-1 -: VERTEX_W];
  assign entry_next    = entry_rdata[LINK_W-1:0];
  assign entry_rd_link = cmd.entry_rd_next ? entry_next : head_link;
  assign entry_rd_addr = IDX_W'(entry_rd_link - LINK_W'(1));

  assign start_ok  = {1'b0, item_a} < vertex_count;
  assign nb_new    = cmd.walk_visit && !visited[entry_nb];
  assign q_wr_en   = (cmd.search_init && start_ok) || nb_new;
  assign q_wr_addr = cmd.search_init ? '0 : wr_idx[QIDX_W-1:0];
  assign q_wr_data = cmd.search_init ? item_a : entry_nb;

  assign status.out_free       = !out_valid || out_ready;
  assign status.add_ok         = ({1'b0, first_vertex} < vertex_count) &&
                                 ({1'b0, second_vertex} < vertex_count) &&
                                 (({1'b0, used} + (LINK_W + 1)'(2)) <=
                                  (LINK_W + 1)'(ENTRY_COUNT));
  assign status.start_ok       = start_ok;
  assign status.queue_empty    = rd_idx == wr_idx;
  assign status.pend_valid     = pend_valid;
  assign status.head_link_zero = head_link == '0;
  assign status.next_link_zero = entry_next == '0;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_a <= first_vertex;
      item_b <= second_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (head_wr_en) begin
      head_mem[head_wr_addr] <= used_inc;
    end
    head_rdata <= head_mem[head_rd_addr];
    head_vld_q <= head_valid[head_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      used       <= '0;
    end else if (cmd.list_clear) begin
      head_valid <= '0;
      used       <= '0;
    end else if (head_wr_en) begin
      head_valid[head_wr_addr] <= 1'b1;
      used                     <= used_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (head_wr_en) begin
      entry_mem[used[IDX_W-1:0]] <= entry_wr_data;
    end
    entry_rdata <= entry_mem[entry_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      queue_mem[q_wr_addr] <= q_wr_data;
    end
    q_rdata <= queue_mem[rd_idx[QIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      wr_idx     <= '0;
      visited    <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.search_init) begin
      rd_idx     <= '0;
      wr_idx     <= start_ok ? QCNT_W'(1) : '0;
      visited    <= start_ok ? (MAX_VERTICES'(1) << item_a) : '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.pop) begin
        rd_idx <= rd_idx + QCNT_W'(1);
      end
      if (nb_new) begin
        wr_idx            <= wr_idx + QCNT_W'(1);
        visited[entry_nb] <= 1'b1;
      end
      if (cmd.pend_capture) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_capture) begin
      pend_vertex <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_kind)
        OUT_MID: begin
          out_vertex <= pend_vertex;
          out_status <= ST_VISITED;
          out_last   <= 1'b0;
        end
        OUT_LAST: begin
          out_vertex <= pend_vertex;
          out_status <= ST_VISITED;
          out_last   <= 1'b1;
        end
        OUT_REJECT: begin
          out_vertex <= '0;
          out_status <= ST_EDGE_REJECTED;
          out_last   <= 1'b1;
        end
        OUT_BAD_START: begin
          out_vertex <= '0;
          out_status <= ST_BAD_START;
          out_last   <= 1'b1;
        end
        default: begin
          out_vertex <= '0;
          out_status <= ST_VISITED;
          out_last   <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bfs_pkg::*;

  localparam int EDGE_LIMIT = 256;
  localparam int ENTRY_SLOTS = 2 * EDGE_LIMIT;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;
  // request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    status_t             status;
    logic                last;
  } bfs_result_t;

  // one row of the directed plan: either a vertex_count write or a request
  typedef struct packed {
    logic                set_count;
    logic [VCOUNT_W-1:0] count;
    logic [REQ_W-1:0]    kind;
    logic [VERTEX_W-1:0] first;
    logic [VERTEX_W-1:0] second;
    logic                typed;
    logic [VERTEX_W-1:0] typed_vertex;
    status_t             typed_status;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bfs_req_if req_ch ();
  bfs_res_if res_ch ();

  graph_breadth_first_search #(.MAX_EDGES(EDGE_LIMIT)) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // graph model
  logic [VCOUNT_W-1:0] vertex_count_m;
  int unsigned         list_head_m [MAX_VERTICES];
  logic [VERTEX_W-1:0] entry_neighbor_m [ENTRY_SLOTS];
  int unsigned         entry_next_m [ENTRY_SLOTS];
  int unsigned         entries_used_m;

  bfs_result_t predicted [$];
  bfs_result_t results_due [$];
  bfs_result_t got;
  bfs_result_t want;
  int          failures;
  int          quiet_cycles;
  bit          calm;

  plan_row_t directed_plan [0:27] = '{
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd0,  6'd0,  1'b1, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd63, 6'd63, 1'b1, 6'd63, ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd0,  6'd63, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd63, 6'd62, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd0,  6'd1,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd1,  6'd2,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd5,  6'd5,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd2,  6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd0,  6'd63, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd5,  6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_RESERVED, 6'd63, 6'd63, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd62, 6'd1,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd62, 6'd21, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_CLEAR,    6'd42, 6'd21, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd0,  6'd0,  1'b1, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd42, 6'd21, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd21, 6'd42, 1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd21, 6'd42, 1'b0, 6'd0,  ST_VISITED},
    '{1'b1, 7'd1,   REQ_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd0,  6'd1,  1'b1, 6'd0,  ST_EDGE_REJECTED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd1,  6'd0,  1'b1, 6'd0,  ST_EDGE_REJECTED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd1,  6'd0,  1'b1, 6'd0,  ST_BAD_START},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd0,  6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b1, 7'd127, REQ_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd63, 6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_ADD_EDGE, 6'd63, 6'd0,  1'b0, 6'd0,  ST_VISITED},
    '{1'b0, 7'd0,   REQ_SEARCH,   6'd0,  6'd0,  1'b0, 6'd0,  ST_VISITED}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void link_entry(logic [VERTEX_W-1:0] owner, logic [VERTEX_W-1:0] nb);
    entry_neighbor_m[entries_used_m] = nb;
    entry_next_m[entries_used_m] = list_head_m[owner];
    list_head_m[owner] = entries_used_m + 1;
    entries_used_m++;
  endfunction

  // fills 'predicted' with the results one request produces, in order
  function automatic void predict_bfs(logic [REQ_W-1:0] kind, logic [VERTEX_W-1:0] a,
                                      logic [VERTEX_W-1:0] b);
    int unsigned         span;
    int unsigned         link;
    logic [VERTEX_W-1:0] cur;
    logic [VERTEX_W-1:0] nb;
    logic [MAX_VERTICES-1:0] seen;
    logic [VERTEX_W-1:0] frontier [$];
    span = (vertex_count_m > MAX_VERTICES) ? MAX_VERTICES : vertex_count_m;
    predicted.delete();
    case (kind)
      REQ_ADD_EDGE: begin
        if (a >= span || b >= span || entries_used_m + 2 > ENTRY_SLOTS) begin
          predicted.push_back('{6'd0, ST_EDGE_REJECTED, 1'b1});
        end else begin
          link_entry(a, b);
          link_entry(b, a);
        end
      end
      REQ_CLEAR: begin
        foreach (list_head_m[i]) list_head_m[i] = 0;
        entries_used_m = 0;
      end
      REQ_SEARCH: begin
        seen = '0;
        if (a >= span) begin
          predicted.push_back('{6'd0, ST_BAD_START, 1'b1});
        end else begin
          seen[a] = 1'b1;
          frontier.push_back(a);
          while (frontier.size() != 0) begin
            cur = frontier.pop_front();
            predicted.push_back('{cur, ST_VISITED, 1'b0});
            link = list_head_m[cur];
            while (link != 0) begin
              nb = entry_neighbor_m[link-1];
              if (!seen[nb]) begin
                seen[nb] = 1'b1;
                frontier.push_back(nb);
              end
              link = entry_next_m[link-1];
            end
          end
          predicted[predicted.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // a fixed expectation replaces the predicted one but the model still advances
  task automatic send(input logic [REQ_W-1:0] kind, input logic [VERTEX_W-1:0] a,
                      input logic [VERTEX_W-1:0] b, input bit typed = 1'b0,
                      input logic [VERTEX_W-1:0] typed_vertex = '0,
                      input status_t typed_status = ST_VISITED);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.first_vertex <= a;
    req_ch.second_vertex <= b;
    do @(posedge clk); while (!req_ch.ready);
    predict_bfs(kind, a, b);
    if (typed) begin
      results_due.push_back('{typed_vertex, typed_status, 1'b1});
    end else begin
      foreach (predicted[i]) results_due.push_back(predicted[i]);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
    drain();
    // an accepted edge gives no result and may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_VERTEX_COUNT;
    pwdata <= {{(32-VCOUNT_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    vertex_count_m = value;
  endtask

  task automatic run_random(input int count);
    int unsigned         span;
    int unsigned         pick;
    logic [REQ_W-1:0]    kind;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
    span = (vertex_count_m > MAX_VERTICES) ? MAX_VERTICES : vertex_count_m;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      a = VERTEX_W'($urandom_range(0, span - 1));
      b = VERTEX_W'($urandom_range(0, span - 1));
      if (pick < 55) begin
        kind = REQ_ADD_EDGE;
      end else if (pick < 63) begin
        kind = REQ_ADD_EDGE;
        if (pick[0]) a = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
        else b = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
      end else if (pick < 85) begin
        kind = REQ_SEARCH;
        b = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
      end else if (pick < 90) begin
        kind = REQ_SEARCH;
        a = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
      end else if (pick < 94) begin
        kind = REQ_CLEAR;
        a = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
      end else begin
        kind = REQ_RESERVED;
        a = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
        b = VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
      end
      if (!calm && $urandom_range(0, 19) == 0) drain();
      send(kind, a, b);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.visited_vertex, res_ch.result_status, res_ch.last_result};
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: vertex %0d status %0d last %0d",
                   got.vertex, got.status, got.last);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected vertex %0d status %0d last %0d, got %0d %0d %0d",
                     want.vertex, want.status, want.last, got.vertex, got.status, got.last);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    res_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && !rst && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    failures = 0;
    quiet_cycles = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ADD_EDGE;
    req_ch.first_vertex = '0;
    req_ch.second_vertex = '0;
    vertex_count_m = VCOUNT_RESET;
    entries_used_m = 0;
    foreach (list_head_m[i]) list_head_m[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].set_count)
        write_vertex_count(directed_plan[i].count);
      else
        send(directed_plan[i].kind, directed_plan[i].first, directed_plan[i].second,
             directed_plan[i].typed, directed_plan[i].typed_vertex,
             directed_plan[i].typed_status);
    end

    write_vertex_count(7'd16);
    run_random(20);
    write_vertex_count(7'd2);
    run_random(10);
    write_vertex_count(7'd40);
    run_random(25);
    write_vertex_count(7'd64);
    calm = 1'b1;
    run_random(20);

    drain();
    repeat (30) @(posedge clk);
    if (failures == 0 && results_due.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
design/bfs_pkg.sv
design/bfs_if.sv
design/bfs_ctrl.sv
design/bfs_dpath.sv
design/graph_breadth_first_search.sv
dv/testbench.sv
